// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the checker file.
// Each macro takes a label, the clock, the active-low reset, a condition and
// the property that must follow from it.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ===== rtl/setap_pkg.sv =====
// ----------------------------------------------------------------------------
// setap_pkg
// Types, codes and helper functions for the SETAP command line parser.
// ----------------------------------------------------------------------------
package setap_pkg;

    // Parser phases along one line.
    typedef enum logic [3:0] {
        PH_VERB  = 4'd0,
        PH_SEP   = 4'd1,
        PH_GAP1  = 4'd2,
        PH_SSID  = 4'd3,
        PH_GAP2  = 4'd4,
        PH_PSK   = 4'd5,
        PH_TRAIL = 4'd6,
        PH_FAIL  = 4'd7
    } phase_t;

    // Role tags carried with each result item.
    localparam logic [1:0] ROLE_OTHER   = 2'd0;
    localparam logic [1:0] ROLE_SSID    = 2'd1;
    localparam logic [1:0] ROLE_PSK     = 2'd2;
    localparam logic [1:0] ROLE_VERDICT = 2'd3;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SSID_MIN = 3'd0,
        CFG_SSID_MAX = 3'd1,
        CFG_PSK_MIN  = 3'd2,
        CFG_PSK_MAX  = 3'd3,
        CFG_SSID_CAP = 3'd4,
        CFG_PSK_CAP  = 3'd5
    } cfg_idx_t;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Configuration register file contents.
    typedef struct packed {
        logic [7:0] ssid_min_len;
        logic [7:0] ssid_max_len;
        logic [7:0] psk_min_len;
        logic [7:0] psk_max_len;
        logic [8:0] ssid_capacity;
        logic [8:0] psk_capacity;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        ssid_min_len:  8'd1,
        ssid_max_len:  8'd32,
        psk_min_len:   8'd8,
        psk_max_len:   8'd63,
        ssid_capacity: 9'd33,
        psk_capacity:  9'd64
    };

    // Per-line control state; the token length travels beside it.
    typedef struct packed {
        phase_t     phase;
        logic [2:0] verb_position;
        logic       line_failed;
        logic       terminated;
    } line_state_t;

    localparam line_state_t LINE_CLEAR = '{
        phase:         PH_VERB,
        verb_position: 3'd0,
        line_failed:   1'b0,
        terminated:    1'b0
    };

    // One result item.
    typedef struct packed {
        logic [7:0] byte_val;
        logic [1:0] role;
        logic       accepted;
        logic       last;
    } result_t;

    localparam int VERB_LEN = 5;

    // Upper-case letters of the verb, by position.
    function automatic logic [7:0] verb_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h53;  // S
            3'd1:    c = 8'h45;  // E
            3'd2:    c = 8'h54;  // T
            3'd3:    c = 8'h41;  // A
            3'd4:    c = 8'h50;  // P
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Space or horizontal tab.
    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09);
    endfunction

    // Fold lower-case ASCII letters onto upper case.
    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
    endfunction

endpackage

// ===== rtl/setap_command_line_parser.sv =====
// ----------------------------------------------------------------------------
// setap_command_line_parser
// A result item is registered and appears in the cycle after its input item is taken.
// Throughput: one item per cycle; the single output register sets the rate,
// and input stalls only while that register holds an item being stalled.
// Reset clears the line state and the output valid and loads the register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module setap_command_line_parser
    import setap_pkg::*;
#(
    parameter int MAX_LEN = 255
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            char_in,
    input  logic                  line_end,
    // Output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            byte_out,
    output logic [1:0]            role,
    output logic                  accepted,
    output logic                  last,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    line_state_t      st_reg;
    line_state_t      st_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    result_t          res_reg;
    result_t          res_next;
    logic             out_valid_reg;
    logic             take_in;

    // The input waits only while a stalled result occupies the output register.
    assign in_stall  = out_valid_reg && out_stall;
    assign take_in   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    setap_parse_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .st       (st_reg),
        .len      (len_reg),
        .cfg      (cfg_reg),
        .char_in  (char_in),
        .line_end (line_end),
        .st_next  (st_next),
        .len_next (len_next),
        .res      (res_next)
    );

    // Register writes decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SSID_MIN: cfg_next.ssid_min_len  = cfg_data[7:0];
                CFG_SSID_MAX: cfg_next.ssid_max_len  = cfg_data[7:0];
                CFG_PSK_MIN:  cfg_next.psk_min_len   = cfg_data[7:0];
                CFG_PSK_MAX:  cfg_next.psk_max_len   = cfg_data[7:0];
                CFG_SSID_CAP: cfg_next.ssid_capacity = cfg_data;
                CFG_PSK_CAP:  cfg_next.psk_capacity  = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // Control state, registers and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= LINE_CLEAR;
            len_reg       <= '0;
            cfg_reg       <= CFG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (take_in)
            begin
                st_reg        <= st_next;
                len_reg       <= len_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign byte_out  = res_reg.byte_val;
    assign role      = res_reg.role;
    assign accepted  = res_reg.accepted;
    assign last      = res_reg.last;

endmodule

// ===== rtl/setap_parse_core.sv =====
// ----------------------------------------------------------------------------
// setap_parse_core
// Next-state and result logic for one item of the command line parser.
// ----------------------------------------------------------------------------
module setap_parse_core
    import setap_pkg::*;
#(
    parameter int MAX_LEN = 255,
    localparam int LEN_W = $clog2(MAX_LEN + 1)
) (
    input  line_state_t      st,
    input  logic [LEN_W-1:0] len,
    input  cfg_t             cfg,
    input  logic [7:0]       char_in,
    input  logic             line_end,
    output line_state_t      st_next,
    output logic [LEN_W-1:0] len_next,
    output result_t          res
);

    // Common width for length compares against 8-bit and 9-bit registers.
    localparam int CW = (LEN_W > 9) ? LEN_W : 9;

    function automatic logic len_ok(input logic [LEN_W-1:0] l, input logic [7:0] lo,
                                    input logic [7:0] hi, input logic [8:0] cap);
        logic [CW-1:0] lx;
        lx = CW'(l);
        return (l != '0) && (lx >= CW'(lo)) && (lx <= CW'(hi)) && (lx < CW'(cap));
    endfunction

    logic       ssid_ok;
    logic       psk_ok;
    logic       fin_ok;
    logic       at_max;
    logic       do_fail;
    logic       blank;
    logic [7:0] upper;

    assign ssid_ok = len_ok(len, cfg.ssid_min_len, cfg.ssid_max_len, cfg.ssid_capacity);
    assign psk_ok  = len_ok(len, cfg.psk_min_len, cfg.psk_max_len, cfg.psk_capacity);
    assign at_max  = (len >= LEN_W'(MAX_LEN));
    assign blank   = is_blank(char_in);
    assign upper   = to_upper(char_in);

    // A line is good at its end only inside or after the passphrase.
    assign fin_ok = !st.line_failed &&
                    (((st.phase == PH_PSK) && psk_ok) || (st.phase == PH_TRAIL));

    // Phase transitions and role tagging.
    always_comb
    begin
        st_next      = st;
        len_next     = len;
        do_fail      = 1'b0;
        res.byte_val = char_in;
        res.role     = ROLE_OTHER;
        res.accepted = 1'b0;
        res.last     = 1'b0;

        if (line_end)
        begin
            res.byte_val = '0;
            res.role     = ROLE_VERDICT;
            res.accepted = st.terminated ? !st.line_failed : fin_ok;
            res.last     = 1'b1;
            st_next      = LINE_CLEAR;
            len_next     = '0;
        end
        else if (!st.terminated)
        begin
            if (char_in == 8'h00)
            begin
                // The terminator judges the line here.
                do_fail            = !fin_ok;
                st_next.terminated = 1'b1;
            end
            else
            begin
                unique case (st.phase)
                    PH_VERB:
                    begin
                        if (upper != verb_char(st.verb_position))
                        begin
                            do_fail = 1'b1;
                        end
                        else
                        begin
                            st_next.verb_position = st.verb_position + 3'd1;
                            if (st.verb_position == 3'(VERB_LEN - 1))
                            begin
                                st_next.phase = PH_SEP;
                            end
                        end
                    end
                    PH_SEP:
                    begin
                        if (blank)
                        begin
                            st_next.phase = PH_GAP1;
                        end
                        else
                        begin
                            do_fail = 1'b1;
                        end
                    end
                    PH_GAP1:
                    begin
                        if (!blank)
                        begin
                            st_next.phase = PH_SSID;
                            len_next      = LEN_W'(1);
                            res.role      = ROLE_SSID;
                        end
                    end
                    PH_SSID:
                    begin
                        if (blank)
                        begin
                            if (ssid_ok)
                            begin
                                st_next.phase = PH_GAP2;
                                len_next      = '0;
                            end
                            else
                            begin
                                do_fail = 1'b1;
                            end
                        end
                        else if (at_max)
                        begin
                            do_fail = 1'b1;
                        end
                        else
                        begin
                            len_next = len + LEN_W'(1);
                            res.role = ROLE_SSID;
                        end
                    end
                    PH_GAP2:
                    begin
                        if (!blank)
                        begin
                            st_next.phase = PH_PSK;
                            len_next      = LEN_W'(1);
                            res.role      = ROLE_PSK;
                        end
                    end
                    PH_PSK:
                    begin
                        if (blank)
                        begin
                            if (psk_ok)
                            begin
                                st_next.phase = PH_TRAIL;
                            end
                            else
                            begin
                                do_fail = 1'b1;
                            end
                        end
                        else if (at_max)
                        begin
                            do_fail = 1'b1;
                        end
                        else
                        begin
                            len_next = len + LEN_W'(1);
                            res.role = ROLE_PSK;
                        end
                    end
                    PH_TRAIL:
                    begin
                        if (!blank)
                        begin
                            do_fail = 1'b1;
                        end
                    end
                    PH_FAIL:
                    begin
                        // Failed lines only pass bytes through.
                    end
                    default:
                    begin
                        do_fail = 1'b1;
                    end
                endcase
            end

            if (do_fail)
            begin
                st_next.phase       = PH_FAIL;
                st_next.line_failed = 1'b1;
            end
        end
    end

endmodule

// ===== rtl/setap_checker.sv =====
// ----------------------------------------------------------------------------
// setap_checker
// Port-level checks on the parser's result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module setap_checker
    import setap_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] char_in,
    input logic       line_end,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] byte_out,
    input logic [1:0] role,
    input logic       accepted,
    input logic       last
);

    logic in_take;

    assign in_take = in_valid && !in_stall;

    // A verdict item is tagged as such and carries a zero byte.
    `ASSERT_SAME(a_verdict_form, clk, rst_n, out_valid && last, (role == ROLE_VERDICT) && (byte_out == 8'h00))

    // Byte items never claim acceptance.
    `ASSERT_SAME(a_byte_not_accepted, clk, rst_n, out_valid && !last, !accepted && (role != ROLE_VERDICT))

    // A taken byte shows up next cycle, unchanged, as a byte item.
    `ASSERT_NEXT(a_byte_pass, clk, rst_n, in_take && !line_end, out_valid && !last && (byte_out == $past(char_in)))

    // A taken line end yields a verdict next cycle.
    `ASSERT_NEXT(a_line_end_verdict, clk, rst_n, in_take && line_end, out_valid && last)

    // A stalled result holds its payload.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(byte_out) && $stable(role) && $stable(last))

endmodule

bind setap_command_line_parser setap_checker u_setap_checker (.*);

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// SETAP command line parser testbench
// Feeds command lines one byte per item, each closed by an end-of-line item,
// under several length limit settings, and checks every tagged byte and every
// verdict against a cycle-free model of the parser kept in this file. Both
// channels idle and stall at random, with long receiver hold-offs and full
// drains between limit settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import setap_pkg::*;

    localparam int          TOKEN_LIMIT  = 255;
    localparam int          VERB_CHARS   = 5;
    localparam logic [39:0] VERB_WORD    = "SETAP";
    localparam logic [7:0]  NUL          = 8'h00;
    localparam logic [7:0]  SPACE        = 8'h20;
    localparam logic [7:0]  TAB          = 8'h09;
    localparam logic [7:0]  LOWER_A      = 8'h61;
    localparam logic [7:0]  LOWER_Z      = 8'h7A;
    localparam logic [7:0]  CASE_OFFSET  = 8'h20;
    localparam int          PHASE_ITEMS  = 45;
    localparam int          DRAIN_EXTRA  = 4;
    localparam int          LONG_HOLD    = 64;
    localparam int          RUN_LIMIT_NS = 1_000_000;

    // One entry of the stimulus queue: a line item, a register write or a drain.
    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_CFG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct packed {
        step_kind_t kind;
        logic [7:0] ch;
        logic       eol;
        cfg_idx_t   idx;
        logic [8:0] val;
        logic [3:0] gap;
    } line_step_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            char_in = 8'h00;
    logic                  line_end = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            byte_out;
    logic [1:0]            role;
    logic                  accepted;
    logic                  last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = CFG_SSID_MIN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    line_step_t  line_items[$];
    logic [7:0]  line_buf[$];
    result_t     pending_tags[$];
    cfg_t        stim_cfg;
    int          stim_items;
    int          mismatch_count;
    int          results_seen;

    // Driver state.
    line_step_t  cur_step;
    bit          drv_busy;
    int unsigned wait_left;

    // Receiver state.
    int unsigned taken;
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned stall_mode;

    // Parser model state and its copy of the limit registers.
    cfg_t        shadow_cfg;
    phase_t      ln_phase;
    int          verb_idx;
    int unsigned tok_len;
    bit          ln_failed;
    bit          ln_ended;

    setap_command_line_parser #(
        .MAX_LEN(TOKEN_LIMIT)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_in   (char_in),
        .line_end  (line_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .byte_out  (byte_out),
        .role      (role),
        .accepted  (accepted),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------

    function automatic logic [7:0] verb_letter(input int p);
        return VERB_WORD[39 - 8 * p -: 8];
    endfunction

    function automatic bit is_gap_char(input logic [7:0] c);
        return (c == SPACE) || (c == TAB);
    endfunction

    function automatic bit len_in_bounds(input int unsigned n, input int unsigned lo,
                                         input int unsigned hi, input int unsigned cap);
        return (n != 0) && (n >= lo) && (n <= hi) && (n < cap);
    endfunction

    function automatic void clear_line_state();
        ln_phase  = PH_VERB;
        verb_idx  = 0;
        tok_len   = 0;
        ln_failed = 1'b0;
        ln_ended  = 1'b0;
    endfunction

    function automatic void reject_line();
        ln_failed = 1'b1;
        ln_phase  = PH_FAIL;
    endfunction

    // A line may only end inside the passphrase or in the trailing blanks.
    function automatic void judge_line();
        bit ok;
        ok = 1'b0;
        if (!ln_failed)
        begin
            if (ln_phase == PH_PSK)
                ok = len_in_bounds(tok_len, shadow_cfg.psk_min_len,
                                   shadow_cfg.psk_max_len, shadow_cfg.psk_capacity);
            else if (ln_phase == PH_TRAIL)
                ok = 1'b1;
        end
        if (!ok)
            reject_line();
    endfunction

    // Counts one more token byte; a byte past the saturated length fails the line.
    function automatic bit grow_token();
        if (tok_len >= TOKEN_LIMIT)
        begin
            reject_line();
            return 1'b0;
        end
        tok_len++;
        return 1'b1;
    endfunction

    // Tags one line item and advances the line state.
    function automatic result_t parse_item(input logic [7:0] ch, input logic eol);
        result_t    r;
        logic [7:0] up;
        r = '{byte_val: ch, role: ROLE_OTHER, accepted: 1'b0, last: 1'b0};
        if (eol)
        begin
            if (!ln_ended)
                judge_line();
            r.byte_val = NUL;
            r.role     = ROLE_VERDICT;
            r.accepted = !ln_failed;
            r.last     = 1'b1;
            clear_line_state();
            return r;
        end
        if (!ln_ended)
        begin
            if (ch == NUL)
            begin
                if (ln_phase == PH_PSK || ln_phase == PH_TRAIL)
                    judge_line();
                else
                    reject_line();
                ln_ended = 1'b1;
            end
            else
            begin
                case (ln_phase)
                    PH_VERB:
                    begin
                        up = (ch >= LOWER_A && ch <= LOWER_Z) ? ch - CASE_OFFSET : ch;
                        if (up != verb_letter(verb_idx))
                            reject_line();
                        else
                        begin
                            verb_idx++;
                            if (verb_idx >= VERB_CHARS)
                                ln_phase = PH_SEP;
                        end
                    end
                    PH_SEP:
                    begin
                        if (is_gap_char(ch))
                            ln_phase = PH_GAP1;
                        else
                            reject_line();
                    end
                    PH_GAP1:
                    begin
                        if (!is_gap_char(ch))
                        begin
                            ln_phase = PH_SSID;
                            tok_len  = 1;
                            r.role   = ROLE_SSID;
                        end
                    end
                    PH_SSID:
                    begin
                        if (is_gap_char(ch))
                        begin
                            if (len_in_bounds(tok_len, shadow_cfg.ssid_min_len,
                                              shadow_cfg.ssid_max_len,
                                              shadow_cfg.ssid_capacity))
                            begin
                                ln_phase = PH_GAP2;
                                tok_len  = 0;
                            end
                            else
                                reject_line();
                        end
                        else if (grow_token())
                            r.role = ROLE_SSID;
                    end
                    PH_GAP2:
                    begin
                        if (!is_gap_char(ch))
                        begin
                            ln_phase = PH_PSK;
                            tok_len  = 1;
                            r.role   = ROLE_PSK;
                        end
                    end
                    PH_PSK:
                    begin
                        if (is_gap_char(ch))
                        begin
                            if (len_in_bounds(tok_len, shadow_cfg.psk_min_len,
                                              shadow_cfg.psk_max_len,
                                              shadow_cfg.psk_capacity))
                                ln_phase = PH_TRAIL;
                            else
                                reject_line();
                        end
                        else if (grow_token())
                            r.role = ROLE_PSK;
                    end
                    PH_TRAIL:
                    begin
                        if (!is_gap_char(ch))
                            reject_line();
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------

    function automatic line_step_t make_step(input step_kind_t kind, input logic [7:0] ch,
                                             input logic eol, input cfg_idx_t idx,
                                             input logic [8:0] val, input logic [3:0] gap);
        line_step_t s;
        s.kind = kind;
        s.ch   = ch;
        s.eol  = eol;
        s.idx  = idx;
        s.val  = val;
        s.gap  = gap;
        return s;
    endfunction

    // Waits for the parser to go quiet, then rewrites all six limit registers.
    task automatic set_limits(input int smin, input int smax, input int pmin,
                              input int pmax, input int scap, input int pcap);
        line_items.push_back(make_step(STEP_DRAIN, NUL, 1'b0, CFG_SSID_MIN, '0, '0));
        line_items.push_back(make_step(STEP_CFG, NUL, 1'b0, CFG_SSID_MIN, 9'(smin), '0));
        line_items.push_back(make_step(STEP_CFG, NUL, 1'b0, CFG_SSID_MAX, 9'(smax), '0));
        line_items.push_back(make_step(STEP_CFG, NUL, 1'b0, CFG_PSK_MIN, 9'(pmin), '0));
        line_items.push_back(make_step(STEP_CFG, NUL, 1'b0, CFG_PSK_MAX, 9'(pmax), '0));
        line_items.push_back(make_step(STEP_CFG, NUL, 1'b0, CFG_SSID_CAP, 9'(scap), '0));
        line_items.push_back(make_step(STEP_CFG, NUL, 1'b0, CFG_PSK_CAP, 9'(pcap), '0));
        stim_cfg.ssid_min_len  = 8'(smin);
        stim_cfg.ssid_max_len  = 8'(smax);
        stim_cfg.psk_min_len   = 8'(pmin);
        stim_cfg.psk_max_len   = 8'(pmax);
        stim_cfg.ssid_capacity = 9'(scap);
        stim_cfg.psk_capacity  = 9'(pcap);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    // The verb with each letter in random case.
    task automatic add_verb();
        logic [7:0] letter;
        for (int p = 0; p < VERB_CHARS; p++)
        begin
            letter = verb_letter(p);
            line_buf.push_back($urandom_range(0, 1) ? (letter | CASE_OFFSET) : letter);
        end
    endtask

    task automatic add_blanks(input int n);
        repeat (n)
            line_buf.push_back($urandom_range(0, 1) ? SPACE : TAB);
    endtask

    // Token bytes are any nonzero byte that is not a blank.
    task automatic add_token(input int n);
        logic [7:0] c;
        repeat (n)
        begin
            do
                c = 8'($urandom_range(1, 255));
            while (is_gap_char(c));
            line_buf.push_back(c);
        end
    endtask

    // Token lengths cluster around the limits in force.
    function automatic int pick_len(input int lo, input int hi, input int cap);
        int n;
        case ($urandom_range(0, 7))
            0: n = lo;
            1: n = lo - 1;
            2: n = hi;
            3: n = hi + 1;
            4: n = cap - 1;
            5: n = cap;
            default: n = $urandom_range(1, 12);
        endcase
        if (n < 1)
            n = 1;
        if (n > 40)
            n = $urandom_range(1, 40);
        return n;
    endfunction

    // Queues the bytes of the line buffer and the end-of-line item.
    task automatic send_line();
        bit fast;
        fast = ($urandom_range(0, 3) == 0);
        foreach (line_buf[i])
            line_items.push_back(make_step(STEP_ITEM, line_buf[i], 1'b0, CFG_SSID_MIN, '0,
                                           fast ? 4'd0 : 4'($urandom_range(0, 11))));
        line_items.push_back(make_step(STEP_ITEM, NUL, 1'b1, CFG_SSID_MIN, '0,
                                       fast ? 4'd0 : 4'($urandom_range(0, 11))));
        stim_items += line_buf.size() + 1;
        line_buf.delete();
    endtask

    // Mostly well-formed lines; the rest are corrupted, truncated or plain noise.
    task automatic build_random_line();
        int kind;
        int pos;
        kind = $urandom_range(0, 9);
        add_verb();
        add_blanks($urandom_range(1, 3));
        add_token(pick_len(stim_cfg.ssid_min_len, stim_cfg.ssid_max_len,
                           stim_cfg.ssid_capacity));
        add_blanks($urandom_range(1, 3));
        add_token(pick_len(stim_cfg.psk_min_len, stim_cfg.psk_max_len,
                           stim_cfg.psk_capacity));
        if ($urandom_range(0, 1))
            add_blanks($urandom_range(1, 2));
        case (kind)
            7:
            begin
                pos = $urandom_range(0, line_buf.size() - 1);
                line_buf[pos] = 8'($urandom_range(0, 255));
            end
            8:
            begin
                line_buf.delete();
                repeat ($urandom_range(0, 10))
                    line_buf.push_back(($urandom_range(0, 7) == 0) ?
                                       NUL : 8'($urandom_range(1, 255)));
            end
            9:
            begin
                repeat ($urandom_range(1, line_buf.size()))
                    void'(line_buf.pop_back());
                if ($urandom_range(0, 1))
                    line_buf.push_back(NUL);
            end
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    line_buf.push_back(NUL);
                    repeat ($urandom_range(0, 3))
                        line_buf.push_back(8'($urandom_range(0, 255)));
                end
            end
        endcase
        send_line();
    endtask

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch: %s", msg);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued line items and register writes.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic nxt_in_valid;
        logic nxt_cfg_valid;
        nxt_in_valid  = in_valid;
        nxt_cfg_valid = cfg_valid;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                nxt_in_valid = 1'b0;
                drv_busy     = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                nxt_cfg_valid = 1'b0;
                drv_busy      = 1'b0;
            end
            if (!drv_busy && line_items.size() != 0)
            begin
                cur_step  = line_items.pop_front();
                drv_busy  = 1'b1;
                wait_left = (cur_step.kind == STEP_DRAIN) ? DRAIN_EXTRA : cur_step.gap;
            end
            if (drv_busy && !nxt_in_valid && !nxt_cfg_valid)
            begin
                case (cur_step.kind)
                    STEP_ITEM:
                    begin
                        if (wait_left == 0)
                        begin
                            nxt_in_valid = 1'b1;
                            char_in  <= cur_step.ch;
                            line_end <= cur_step.eol;
                        end
                        else
                            wait_left--;
                    end
                    STEP_CFG:
                    begin
                        nxt_cfg_valid = 1'b1;
                        cfg_index <= cur_step.idx;
                        cfg_data  <= cur_step.val;
                    end
                    default:
                    begin
                        // Hold off until every result is back and the extra drain wait has run out.
                        if (pending_tags.size() != 0)
                            wait_left = DRAIN_EXTRA;
                        else if (wait_left == 0)
                            drv_busy = 1'b0;
                        else
                            wait_left--;
                    end
                endcase
            end
        end
        in_valid  <= nxt_in_valid;
        cfg_valid <= nxt_cfg_valid;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall per result, plus two long hold-offs.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                taken++;
                if (taken % 50 == 0)
                    stall_mode = $urandom_range(0, 2);
                stall_left = (stall_mode == 0) ? 0 : $urandom_range(0, 11);
                if (taken == 150 || taken == 600)
                    hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result, then records writes and new expectations.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            clear_line_state();
            shadow_cfg = CFG_RESET;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_tags.size() == 0)
                    flag_mismatch($sformatf("result %0d arrived with none expected",
                                            results_seen));
                else
                begin
                    want = pending_tags.pop_front();
                    if (byte_out !== want.byte_val)
                        flag_mismatch($sformatf("result %0d byte_out %h, expected %h",
                                                results_seen, byte_out, want.byte_val));
                    if (role !== want.role)
                        flag_mismatch($sformatf("result %0d role %0d, expected %0d",
                                                results_seen, role, want.role));
                    if (accepted !== want.accepted)
                        flag_mismatch($sformatf("result %0d accepted %b, expected %b",
                                                results_seen, accepted, want.accepted));
                    if (last !== want.last)
                        flag_mismatch($sformatf("result %0d last %b, expected %b",
                                                results_seen, last, want.last));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SSID_MIN: shadow_cfg.ssid_min_len  = cfg_data[7:0];
                    CFG_SSID_MAX: shadow_cfg.ssid_max_len  = cfg_data[7:0];
                    CFG_PSK_MIN:  shadow_cfg.psk_min_len   = cfg_data[7:0];
                    CFG_PSK_MAX:  shadow_cfg.psk_max_len   = cfg_data[7:0];
                    CFG_SSID_CAP: shadow_cfg.ssid_capacity = cfg_data;
                    CFG_PSK_CAP:  shadow_cfg.psk_capacity  = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
                pending_tags.push_back(parse_item(char_in, line_end));
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int phase_start;
        int a;
        int b;
        int c;
        int d;

        stall_mode = $urandom_range(0, 2);

        // Directed lines under tight limits: empty line, bad verb on the top byte
        // value, a line closed by a zero byte with a later byte ignored, and an
        // SSID over its maximum.
        set_limits(1, 2, 1, 2, 3, 3);
        send_line();
        line_buf.push_back(8'hFF);
        send_line();
        add_text("sEtaP a bc");
        line_buf.push_back(NUL);
        line_buf.push_back(8'hFF);
        send_line();
        add_text("SETAP\tabc d");
        send_line();

        // Random lines under a series of limit settings.
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_limits(CFG_RESET.ssid_min_len, CFG_RESET.ssid_max_len,
                              CFG_RESET.psk_min_len, CFG_RESET.psk_max_len,
                              CFG_RESET.ssid_capacity, CFG_RESET.psk_capacity);
                1:
                begin
                    set_limits(0, 255, 0, 255, 256, 256);
                    // Longest SSID accepted, then a passphrase that overflows the counter.
                    add_verb();
                    add_blanks(1);
                    add_token(255);
                    add_blanks(1);
                    add_token(256);
                    send_line();
                end
                2: set_limits(0, 0, 0, 0, 0, 0);
                4: set_limits($urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 255),
                              $urandom_range(0, 256), $urandom_range(0, 256));
                5: set_limits(6, 2, 1, 255, 256, 3);
                default:
                begin
                    a = $urandom_range(0, 4);
                    b = a + $urandom_range(0, 6);
                    c = $urandom_range(0, 4);
                    d = c + $urandom_range(0, 6);
                    set_limits(a, b, c, d, b + $urandom_range(0, 2), d + $urandom_range(0, 2));
                end
            endcase
            phase_start = stim_items;
            while (stim_items - phase_start < PHASE_ITEMS)
                build_random_line();
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (line_items.size() != 0 || drv_busy || pending_tags.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/setap_pkg.sv
rtl/setap_parse_core.sv
rtl/setap_command_line_parser.sv
rtl/setap_checker.sv
verif/testbench.sv
